// ===== rtl/rpsc_pkg.sv =====
// shared types, constants and widths of the ramped pi speed controller
package rpsc_pkg;

    localparam int CHANNELS_DEF = 8;

    // configuration register map, byte address = 4 * index
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI_GAIN        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_STEP       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

    localparam logic [23:0] KP_GAIN_RST        = 24'd167772;
    localparam logic [23:0] KI_GAIN_RST        = 24'd1678;
    localparam logic [15:0] TICK_PERIOD_RST    = 16'd3277;
    localparam logic [14:0] MAX_STEP_RST       = 15'd30;
    localparam logic [14:0] INTEGRAL_LIMIT_RST = 15'd4000;

    // datapath widths
    localparam int ERR_W  = 17;   // setpoint minus measured speed
    localparam int PINT_W = 33;   // error * dt, Q.16
    localparam int ACC_W  = 34;   // integral plus increment before clamp
    localparam int INT_W  = 32;   // stored integral, Q15.16
    localparam int PKP_W  = 41;   // kp * error
    localparam int PKI_W  = 56;   // ki * integral
    localparam int SUM_W  = 58;   // kp * error * 2^16 + ki * integral, Q.40
    localparam int SAT_W  = 42;   // sum after saturation to +/- 2^40
    localparam int ONE_SHIFT = 40;
    localparam int MAG_LSB = 28;  // drive = |v| / (5 * 2^28)
    localparam int MAG_W  = 13;
    localparam int Q_W    = 10;
    localparam int DRIVE_W = 11;

    // divide by five: (a * 52429) >> 18 is exact for a below 2^18
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int DIV5_SHIFT = 18;
    localparam int DIVP_W = MAG_W + 16;

    typedef struct packed {
        logic [23:0] kp_gain;
        logic [23:0] ki_gain;
        logic [15:0] tick_period;
        logic [14:0] max_step;
        logic [14:0] integral_limit;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic ramp;
        logic mult;
        logic clamp;
        logic mix;
        logic sat;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/rpsc_in_if.sv =====
// request channel: one control tick for one channel
interface rpsc_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         channel;
    logic               enabled;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;

    modport source (output valid, channel, enabled, target_speed, measured_speed,
                    input ready);
    modport sink (input valid, channel, enabled, target_speed, measured_speed,
                  output ready);
endinterface

// ===== rtl/rpsc_out_if.sv =====
// result channel: drive value for one channel
interface rpsc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_channel;
    logic signed [10:0] drive;

    modport source (output valid, out_channel, drive, input ready);
    modport sink (input valid, out_channel, drive, output ready);
endinterface

// ===== rtl/ramped_pi_speed_controller_core.sv =====
// top level of the ramped pi speed controller
//
//  port    dir   handshake          payload
//  i_req   in    valid/ready        channel, enabled, target_speed, measured_speed
//  o_rsp   out   valid/ready        out_channel, drive
//  apb     in    psel/penable       paddr, pwdata, prdata (kp, ki, dt, max step, limit)
//
// after its accepting edge a request passes the ramp, two multiply stages
// around the integral clamp, saturation and the divide by five into the output
// register; the next request is taken only after the result is loaded, so only
// one request is in work at a time. i_rst_n is synchronous and clears all channel state.
// a result that is not taken holds the last step until the output register frees.
module ramped_pi_speed_controller_core #(
    parameter int CHANNELS = rpsc_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rpsc_in_if.sink                     i_req,
    rpsc_out_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpsc_pkg::ADDR_W-1:0] paddr,
    input  logic [rpsc_pkg::DATA_W-1:0] pwdata,
    output logic [rpsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    rpsc_pkg::t_cfg    cfg;
    rpsc_pkg::t_dp_cmd cmd;
    rpsc_pkg::t_dp_sts sts;
    logic              ready;

    rpsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rpsc_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (cfg),
        .i_channel        (i_req.channel),
        .i_enabled        (i_req.enabled),
        .i_target_speed   (i_req.target_speed),
        .i_measured_speed (i_req.measured_speed),
        .o_valid          (o_rsp.valid),
        .i_ready          (o_rsp.ready),
        .o_out_channel    (o_rsp.out_channel),
        .o_drive          (o_rsp.drive)
    );

    assign i_req.ready = ready;

    // a request in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while a previous one is in work");

    // a new result appears only from the final sequencer step
    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(cmd.load_out))
        else $error("result valid without a load from the sequencer");

    // drive stays within the scaled full-scale range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.drive <= 11'sd819 && o_rsp.drive >= -11'sd819))
        else $error("drive out of range");

    // the result register is never overwritten while untaken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_rsp.valid || o_rsp.ready))
        else $error("untaken result overwritten");

endmodule

// ===== rtl/rpsc_regs.sv =====
// apb configuration registers
module rpsc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpsc_pkg::ADDR_W-1:0] paddr,
    input  logic [rpsc_pkg::DATA_W-1:0] pwdata,
    output logic [rpsc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rpsc_pkg::t_cfg             o_cfg
);

    rpsc_pkg::t_cfg r_cfg;
    logic [rpsc_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[rpsc_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain        <= rpsc_pkg::KP_GAIN_RST;
            r_cfg.ki_gain        <= rpsc_pkg::KI_GAIN_RST;
            r_cfg.tick_period    <= rpsc_pkg::TICK_PERIOD_RST;
            r_cfg.max_step       <= rpsc_pkg::MAX_STEP_RST;
            r_cfg.integral_limit <= rpsc_pkg::INTEGRAL_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                rpsc_pkg::REG_KP_GAIN:        r_cfg.kp_gain        <= pwdata[23:0];
                rpsc_pkg::REG_KI_GAIN:        r_cfg.ki_gain        <= pwdata[23:0];
                rpsc_pkg::REG_TICK_PERIOD:    r_cfg.tick_period    <= pwdata[15:0];
                rpsc_pkg::REG_MAX_STEP:       r_cfg.max_step       <= pwdata[14:0];
                rpsc_pkg::REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rpsc_pkg::REG_KP_GAIN:        prdata = {8'd0, r_cfg.kp_gain};
            rpsc_pkg::REG_KI_GAIN:        prdata = {8'd0, r_cfg.ki_gain};
            rpsc_pkg::REG_TICK_PERIOD:    prdata = {16'd0, r_cfg.tick_period};
            rpsc_pkg::REG_MAX_STEP:       prdata = {17'd0, r_cfg.max_step};
            rpsc_pkg::REG_INTEGRAL_LIMIT: prdata = {17'd0, r_cfg.integral_limit};
            default:                      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/rpsc_ctrl.sv =====
// sequencer that steps one request through the datapath
module rpsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rpsc_pkg::t_dp_sts   i_sts,
    output rpsc_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RAMP  = 7'b0000010,
        ST_MULT  = 7'b0000100,
        ST_CLAMP = 7'b0001000,
        ST_MIX   = 7'b0010000,
        ST_SAT   = 7'b0100000,
        ST_DIV   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_RAMP;
                end
            end
            ST_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // wait here while the output register still holds an untaken result
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rpsc_dp.sv =====
// datapath: per-channel state, ramp, integral clamp, pi mix, scaling
module rpsc_dp #(
    parameter int CHANNELS = rpsc_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rpsc_pkg::t_dp_cmd                  i_cmd,
    output rpsc_pkg::t_dp_sts                  o_sts,
    input  rpsc_pkg::t_cfg                     i_cfg,
    input  logic [2:0]                         i_channel,
    input  logic                               i_enabled,
    input  logic signed [15:0]                 i_target_speed,
    input  logic signed [15:0]                 i_measured_speed,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0]                         o_out_channel,
    output logic signed [rpsc_pkg::DRIVE_W-1:0] o_drive
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ERR_W  = rpsc_pkg::ERR_W;
    localparam int PINT_W = rpsc_pkg::PINT_W;
    localparam int ACC_W  = rpsc_pkg::ACC_W;
    localparam int INT_W  = rpsc_pkg::INT_W;
    localparam int PKP_W  = rpsc_pkg::PKP_W;
    localparam int PKI_W  = rpsc_pkg::PKI_W;
    localparam int SUM_W  = rpsc_pkg::SUM_W;
    localparam int SAT_W  = rpsc_pkg::SAT_W;
    localparam int MAG_W  = rpsc_pkg::MAG_W;
    localparam int Q_W    = rpsc_pkg::Q_W;
    localparam int DRIVE_W = rpsc_pkg::DRIVE_W;
    localparam int DIVP_W = rpsc_pkg::DIVP_W;
    localparam logic signed [SUM_W-1:0] SAT_POS =
        SUM_W'(1) << rpsc_pkg::ONE_SHIFT;

    // per-channel state, cleared by reset
    logic signed [15:0]      r_sp_mem  [CHANNELS];
    logic signed [INT_W-1:0] r_int_mem [CHANNELS];

    logic [2:0]              r_ch;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_act;
    logic signed [15:0]      r_tgt;
    logic signed [15:0]      r_meas;
    logic signed [15:0]      r_sp;
    logic signed [ERR_W-1:0] r_err;
    logic signed [PINT_W-1:0] r_pint;
    logic signed [PKP_W-1:0] r_pkp;
    logic signed [INT_W-1:0] r_acc;
    logic signed [PKI_W-1:0] r_pki;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_out_valid;
    logic [2:0]              r_out_ch;
    logic signed [DRIVE_W-1:0] r_out_drive;

    // ramp
    logic signed [16:0] prev_sp, diff, step_s, sp_up, sp_dn;
    logic signed [15:0] n_sp;
    logic signed [ERR_W-1:0] n_err;
    // multiplies
    logic signed [PINT_W:0]  pint_full;
    logic signed [PKP_W:0]   pkp_full;
    logic signed [PKI_W:0]   pki_full;
    // clamp
    logic signed [ACC_W-1:0] acc_sum, lim_pos;
    logic signed [INT_W-1:0] n_acc;
    // mix and saturation
    logic signed [SUM_W-1:0] mix_sum;
    logic signed [SAT_W-1:0] mix_sat, mix_mag;
    // scaling
    logic [DIVP_W-1:0]       quot_prod;
    logic [Q_W-1:0]          quot;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                    in_range;

    assign in_range = int'(i_channel) < CHANNELS;

    always_comb begin
        prev_sp = 17'(r_sp_mem[r_idx]);
        diff    = 17'(r_tgt) - prev_sp;
        step_s  = $signed({2'b00, i_cfg.max_step});
        sp_up   = prev_sp + step_s;
        sp_dn   = prev_sp - step_s;
        if (diff > step_s) begin
            n_sp = sp_up[15:0];
        end else if (diff < -step_s) begin
            n_sp = sp_dn[15:0];
        end else begin
            n_sp = r_tgt;
        end
        n_err = ERR_W'(n_sp) - ERR_W'(r_meas);
    end

    assign pint_full = r_err * $signed({1'b0, i_cfg.tick_period});
    assign pkp_full  = r_err * $signed({1'b0, i_cfg.kp_gain});
    assign pki_full  = r_acc * $signed({1'b0, i_cfg.ki_gain});

    always_comb begin
        acc_sum = ACC_W'(r_int_mem[r_idx]) + ACC_W'(r_pint);
        lim_pos = $signed({3'b000, i_cfg.integral_limit, 16'd0});
        if (acc_sum > lim_pos) begin
            n_acc = lim_pos[INT_W-1:0];
        end else if (acc_sum < -lim_pos) begin
            n_acc = INT_W'(-lim_pos);
        end else begin
            n_acc = acc_sum[INT_W-1:0];
        end
    end

    always_comb begin
        mix_sum = $signed({r_pkp, 16'd0}) + SUM_W'(r_pki);
        if (mix_sum > SAT_POS) begin
            mix_sat = SAT_POS[SAT_W-1:0];
        end else if (mix_sum < -SAT_POS) begin
            mix_sat = SAT_W'(-SAT_POS);
        end else begin
            mix_sat = mix_sum[SAT_W-1:0];
        end
        mix_mag = mix_sat[SAT_W-1] ? -mix_sat : mix_sat;
    end

    always_comb begin
        quot_prod = DIVP_W'(r_mag) * DIVP_W'(rpsc_pkg::DIV5_RECIP);
        quot      = quot_prod[rpsc_pkg::DIV5_SHIFT +: Q_W];
        if (!r_act) begin
            n_drive = '0;
        end else if (r_neg) begin
            n_drive = -$signed({1'b0, quot});
        end else begin
            n_drive = $signed({1'b0, quot});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch   <= i_channel;
            r_idx  <= IDX_W'(i_channel);
            r_act  <= i_enabled && in_range;
            r_tgt  <= i_target_speed;
            r_meas <= i_measured_speed;
        end
        if (i_cmd.ramp) begin
            r_sp  <= n_sp;
            r_err <= n_err;
        end
        if (i_cmd.mult) begin
            r_pint <= pint_full[PINT_W-1:0];
            r_pkp  <= pkp_full[PKP_W-1:0];
        end
        if (i_cmd.clamp) begin
            r_acc <= n_acc;
        end
        if (i_cmd.mix) begin
            r_pki <= pki_full[PKI_W-1:0];
        end
        if (i_cmd.sat) begin
            r_neg <= mix_sat[SAT_W-1];
            r_mag <= mix_mag[rpsc_pkg::MAG_LSB +: MAG_W];
        end
        if (i_cmd.load_out) begin
            r_out_ch    <= r_ch;
            r_out_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_sp_mem[k]  <= '0;
                r_int_mem[k] <= '0;
            end
        end else if (i_cmd.clamp && r_act) begin
            r_sp_mem[r_idx]  <= r_sp;
            r_int_mem[r_idx] <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_out_channel  = r_out_ch;
    assign o_drive        = r_out_drive;

endmodule
